// ===== rtl/cpkl_pkg.sv =====
// ----------------------------------------------------------------------------
// cpkl_pkg: shared types and key logic equations
// Holds the bus sample type, the match address and the next-state
// equations of the eight key bits D8..D15.
// ----------------------------------------------------------------------------
package cpkl_pkg;

  // Address value that triggers the match flag and forces the key to zero.
  localparam logic [7:0] MatchAddress = 8'h75;

  // Key value after a forced clear.
  localparam logic [7:0] KeyZero = 8'h00;

  // One bus sample, address in the lowest bits.
  typedef struct packed {
    logic       upper_strobe;
    logic       rom4_select;
    logic       rom3_select;
    logic [7:0] address;
  } cpkl_item_t;

  // Sum-of-products next-state equations, D8 in bit 0 through D15 in bit 7.
  function automatic logic [7:0] next_key(input logic [7:0] addr, input logic [7:0] k);
    logic a1, a4, a5, m;
    logic d8, d9, d10, d11, d12, d13, d14, d15;
    logic n8, n9, n10, n11, n12, n13, n14, n15;
    a1  = addr[0];
    a4  = addr[3];
    a5  = addr[4];
    m   = (addr == MatchAddress);
    d8  = k[0];
    d9  = k[1];
    d10 = k[2];
    d11 = k[3];
    d12 = k[4];
    d13 = k[5];
    d14 = k[6];
    d15 = k[7];
    n9  = !((a5 & !d13) | (a4 & d15) | (a1 & !d8 & !d15) |
            (a1 & !d10 & !d15) | (a1 & !d12 & !d15) | (a1 & !d15 & !d14) |
            (a1 & d8 & d10 & d12 & d15 & d14) | m);
    n8  = !((a5 & !d14) | (a1 & !d9 & !d14) | (a4 & !d9 & d15) |
            (a4 & !d9 & d13) | (a4 & !d9 & d11) |
            (a4 & d9 & !d11 & !d13 & !d15) | m |
            (a1 & d9 & d8 & d11 & d10 & d13 & d12 & d15 & d14));
    n11 = !((a5 & !d15) | (a1 & !d8 & !d10) | (a1 & !d8 & !d12) |
            (a1 & !d8 & !d14) | (a4 & !d8 & d15) |
            (a1 & d8 & d10 & d12 & d14) | m |
            (a4 & !d9 & d8 & !d11 & !d10 & !d13 & !d12 & !d15 & !d14));
    n10 = !((a5 & !d9) | (a1 & !d11 & !d12) | (a1 & !d11 & !d14) |
            (a4 & !d11 & d15) | (a4 & !d11 & d13) |
            (a4 & d11 & !d13 & !d15) | m |
            (a1 & d8 & d11 & d10 & d13 & d12 & d15 & d14));
    n13 = !((a5 & !d11) | (a1 & !d10 & !d13) | (a1 & !d13 & !d12) |
            (a1 & !d13 & !d14) | (a4 & !d13 & d15) | (a4 & d13 & !d15) |
            (a1 & d8 & d10 & d13 & d12 & d15 & d14) | m);
    n12 = !((a5 & !d10) | (a1 & !d12 & !d14) | (a4 & !d12 & d15) |
            (a4 & d13 & !d12) | (a4 & d11 & !d12) | (a1 & d12 & d14) |
            (a4 & !d9 & !d11 & !d13 & d12 & !d15 & !d14) | m);
    n15 = !((a5 & !d8) | (a1 & !d10 & !d12) | (a1 & !d10 & !d14) |
            (a4 & !d10 & d15) | (a4 & !d10 & d13) | (a1 & d10 & d12 & d14) |
            (a4 & !d9 & !d11 & d10 & !d13 & !d12 & !d15 & !d14) | m);
    n14 = !((a5 & !d12) | (a1 & d14) | (a4 & d15 & !d14) |
            (a4 & d13 & !d14) | (a4 & d11 & !d14) | (a4 & d9 & !d14) |
            (a4 & !d9 & !d11 & !d13 & !d15 & d14) | m);
    return {n15, n14, n13, n12, n11, n10, n9, n8};
  endfunction

endpackage

// ===== rtl/cpkl_core.sv =====
// ----------------------------------------------------------------------------
// cpkl_core: key state and per-sample update
// Tracks the match flag, edge history and key bits, and computes the key
// byte for one bus sample combinationally.
// ----------------------------------------------------------------------------
module cpkl_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  cpkl_pkg::cpkl_item_t   item_i,
  output logic [7:0]             read_data_o
);
  import cpkl_pkg::*;

  logic       match_q, match_d;
  logic       last_rom4_q;
  logic       last_clk_q;
  logic [7:0] key_q, key_d;
  logic [7:0] key_step;
  logic       data_clk;
  logic       data_clk_rise;

  // Latch the match flag on a rising edge of rom4; it selects the data clock now.
  always_comb begin
    match_d = match_q;
    if (item_i.rom4_select && !last_rom4_q) begin
      match_d = (item_i.address == MatchAddress);
    end
  end

  // Derived data clock and its rising edge.
  assign data_clk      = match_d ? item_i.rom3_select : item_i.upper_strobe;
  assign data_clk_rise = data_clk && !last_clk_q;

  // Step the key on a data clock rise, then apply the conditional clears.
  always_comb begin
    key_step = next_key(item_i.address, key_q);
    if (item_i.rom3_select && match_d) begin
      if (item_i.address[3] && item_i.address[1]) begin
        key_step[1] = 1'b0;
      end
      if (item_i.address[2] && item_i.address[0]) begin
        key_step[0] = 1'b0;
      end
    end
    key_d = data_clk_rise ? key_step : key_q;
  end

  // The key byte is visible only while rom3 is active.
  assign read_data_o = item_i.rom3_select ? key_d : KeyZero;

  // State registers advance once per processed sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= 1'b0;
      last_rom4_q <= 1'b0;
      last_clk_q  <= 1'b0;
      key_q       <= KeyZero;
    end else if (step_i) begin
      match_q     <= match_d;
      last_rom4_q <= item_i.rom4_select;
      last_clk_q  <= data_clk;
      key_q       <= key_d;
    end
  end

endmodule

// ===== rtl/copy_protection_key_logic_top.sv =====
// ----------------------------------------------------------------------------
// copy_protection_key_logic_top: stream wrapper of the copy-protection key
// Each input word is one bus sample (address and three strobes); each output
// word is the key byte seen on the data bus for that sample.
//
// Channels: the slave side takes one bus sample per word, tdata holding the
// address in bits 7:0, rom3 in bit 8, rom4 in bit 9 and the upper data
// strobe in bit 10. The master side returns exactly one word per sample,
// the key byte D8..D15 with D8 in bit 0, or zero when rom3 is inactive.
// A sample is captured in an input register, processed by the key logic and
// written to the output register, where its result word is held until the
// receiver takes it.
// Throughput: one word per cycle while the receiver keeps tready high; the
// key update is a single pass of sum-of-products logic against the key register.
// Reset clears the key, the match flag, the edge history and both stage
// valid flags. When the receiver stalls, the output word holds, the input
// register fills and the slave side then deasserts tready; no word is lost.
// ----------------------------------------------------------------------------
module copy_protection_key_logic_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // address[7:0], rom3_select, rom4_select, upper_strobe, 5'b0 fill
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata_o
);
  import cpkl_pkg::*;

  logic       in_valid_q;
  cpkl_item_t in_item_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_free;
  logic       step;
  logic       in_load;
  logic [7:0] core_data;

  // Stage handshake: the output register frees when empty or taken.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= s_axis_tdata_i[10:0];
    end
  end

  // Key logic.
  cpkl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .read_data_o (core_data)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= core_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
